/* rtl/core/gdcl_pkg.sv */
package gdcl_pkg;

	localparam int unsigned RowW = 64;
	localparam int unsigned IdxW = 6;
	localparam int unsigned LabelW = 5;
	localparam int unsigned MaxDepth = 6;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_RUN = 1'b1;

	localparam logic [0:0] REG_CLIQUE_SIZE = 1'b0;
	localparam logic [0:0] REG_VERTEX_COUNT = 1'b1;

	typedef struct packed {
		logic        op;
		logic [5:0]  row_index;
		logic [63:0] row_bits;
	} in_word_t;

	typedef struct packed {
		logic [5:0] vertex;
		logic [4:0] label;
		logic       last;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SCAN,
		ST_READ,
		ST_DESCEND,
		ST_MARK,
		ST_REP_RD,
		ST_REP_OUT
	} state_t;

	// Port from the search engine to the label memory.
	typedef struct packed {
		logic              we;
		logic [5:0]        waddr;
		logic [4:0]        wdata;
		logic              re;
		logic [5:0]        raddr;
	} lbl_req_t;

endpackage

/* rtl/core/gdcl_adj_mem.sv */
module gdcl_adj_mem #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [63:0]            wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [63:0]            rdata
);
	import gdcl_pkg::*;

	logic [63:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/gdcl_lbl_mem.sv */
module gdcl_lbl_mem #(
	parameter int unsigned DEPTH = 64
) (
	input  logic               clk,
	input  gdcl_pkg::lbl_req_t req,
	output logic [4:0]         rdata
);
	import gdcl_pkg::*;

	logic [4:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr[$clog2(DEPTH)-1:0]] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr[$clog2(DEPTH)-1:0]];
		end
	end

endmodule

/* rtl/core/greedy_disjoint_clique_labeler.sv */
// Channel   Direction  Payload     Handshake
// in        input      in_word_t   in_valid / in_stall
// out       output     out_word_t  out_valid / out_stall
// cfg       input      7 bits      cfg_we, cfg_index
// A row load writes one adjacency row. A run clears the labels of the first vertex_count
// vertices (at least one), then searches depth first: a step down to a candidate passes the
// scan, adjacency read and descend states, a step back happens in the scan state, and each
// clique gets a marking pass over all 64 label entries. It then reports one word per vertex.
// Reset clears control state only; adjacency rows are undefined until loaded.
// A stalled output word holds, and the report waits on it.
module greedy_disjoint_clique_labeler #(
	parameter int unsigned MAX_VERTICES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  gdcl_pkg::in_word_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output gdcl_pkg::out_word_t  out_data,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_index,
	input  logic [6:0]           cfg_data
);
	import gdcl_pkg::*;

	localparam int unsigned AW = $clog2(MAX_VERTICES);

	state_t state_q, state_d;
	logic [2:0] size_q;
	logic [6:0] count_q;
	logic [63:0] cand_q [MaxDepth + 1];
	logic [5:0] pos_q [MaxDepth + 1];
	logic [63:0] free_q;
	logic [63:0] pick_q;
	logic [2:0] depth_q;
	logic [4:0] label_q;
	logic [6:0] idx_q;
	logic [2:0] eff_size;
	logic [6:0] nv;
	logic [63:0] adj_rd;
	logic [4:0] lbl_rd;
	lbl_req_t lreq;
	logic adj_we;
	logic [5:0] adj_raddr;
	logic [63:0] cur, above;
	logic found;
	logic [5:0] fpos;
	logic out_valid_q;
	out_word_t out_q;

	function automatic logic [63:0] above_of(input logic [5:0] v);
		logic [63:0] m;
		m = (v == 6'd63) ? 64'd0 : (~64'd0 << (v + 6'd1));
		return m;
	endfunction

	assign eff_size = (size_q < 3'd3) ? 3'd3 : ((size_q > 3'd6) ? 3'd6 : size_q);
	assign nv = (count_q > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : count_q;

	assign cur = cand_q[depth_q];
	always_comb begin
		found = 1'b0;
		fpos = '0;
		for (int i = 63; i >= 0; i--) begin
			if (cur[i]) begin
				found = 1'b1;
				fpos = 6'(i);
			end
		end
	end
	assign above = (fpos == 6'd63) ? 64'd0 : (~64'd0 << (fpos + 6'd1));

	assign adj_we = in_valid && !in_stall && in_data.op == OP_LOAD &&
		32'(in_data.row_index) < MAX_VERTICES;
	assign adj_raddr = pos_q[depth_q];

	gdcl_adj_mem #(.DEPTH(MAX_VERTICES)) u_adj (
		.clk(clk), .we(adj_we), .waddr(in_data.row_index[AW-1:0]),
		.wdata(in_data.row_bits), .raddr(adj_raddr[AW-1:0]), .rdata(adj_rd)
	);

	always_comb begin
		lreq = '0;
		case (state_q)
			ST_CLEAR: begin
				lreq.we = 1'b1;
				lreq.waddr = idx_q[5:0];
				lreq.wdata = '0;
			end
			ST_MARK: begin
				lreq.we = pick_q[idx_q[5:0]];
				lreq.waddr = idx_q[5:0];
				lreq.wdata = label_q;
			end
			ST_REP_RD: begin
				lreq.re = 1'b1;
				lreq.raddr = idx_q[5:0];
			end
			default: ;
		endcase
	end

	gdcl_lbl_mem #(.DEPTH(MAX_VERTICES)) u_lbl (.clk(clk), .req(lreq), .rdata(lbl_rd));

	assign in_stall = state_q != ST_IDLE;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid && in_data.op == OP_RUN) state_d = ST_CLEAR;
			ST_CLEAR: if (idx_q + 7'd1 >= nv) state_d = ST_SCAN;
			ST_SCAN: begin
				if (depth_q == eff_size) state_d = ST_MARK;
				else if (found) state_d = ST_READ;
				else if (depth_q == 3'd0) state_d = (nv == 7'd0) ? ST_IDLE : ST_REP_RD;
			end
			ST_READ: state_d = ST_DESCEND;
			ST_DESCEND: state_d = ST_SCAN;
			ST_MARK: if (idx_q == 7'd63) state_d = ST_SCAN;
			ST_REP_RD: if (!out_valid_q || !out_stall) state_d = ST_REP_OUT;
			ST_REP_OUT: state_d = (idx_q + 7'd1 >= nv) ? ST_IDLE : ST_REP_RD;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			size_q <= 3'd4;
			count_q <= 7'd64;
			idx_q <= '0;
			depth_q <= '0;
			label_q <= 5'd1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_index == REG_CLIQUE_SIZE) size_q <= cfg_data[2:0];
			if (cfg_we && cfg_index == REG_VERTEX_COUNT) count_q <= cfg_data;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					label_q <= 5'd1;
					depth_q <= '0;
					free_q <= (nv >= 7'd64) ? ~64'd0 : ((64'd1 << nv[5:0]) - 64'd1);
					pick_q <= '0;
				end
				ST_CLEAR: begin
					idx_q <= idx_q + 7'd1;
					cand_q[0] <= free_q;
				end
				ST_SCAN: begin
					idx_q <= '0;
					if (depth_q != eff_size) begin
						if (found) begin
							pos_q[depth_q] <= fpos;
							cand_q[depth_q] <= cur & above;
						end else if (depth_q != 3'd0) begin
							depth_q <= depth_q - 3'd1;
							pick_q[pos_q[depth_q - 3'd1]] <= 1'b0;
						end
					end
				end
				ST_DESCEND: begin
					cand_q[depth_q + 3'd1] <= cur & adj_rd & above_of(pos_q[depth_q]);
					pick_q[pos_q[depth_q]] <= 1'b1;
					depth_q <= depth_q + 3'd1;
				end
				ST_MARK: begin
					idx_q <= idx_q + 7'd1;
					if (idx_q == 7'd63) begin
						free_q <= free_q & ~pick_q;
						cand_q[0] <= free_q & ~pick_q;
						pick_q <= '0;
						depth_q <= '0;
						label_q <= label_q + 5'd1;
					end
				end
				ST_REP_OUT: begin
					out_valid_q <= 1'b1;
					out_q.vertex <= idx_q[5:0];
					out_q.label <= lbl_rd;
					out_q.last <= (idx_q + 7'd1 >= nv);
					idx_q <= idx_q + 7'd1;
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall) else $error("input accepted while busy");
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= eff_size) else $error("search depth overflow");
	a_out_only_report: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_REP_OUT)
		else $error("output word outside report");

endmodule
